// File: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent assertion helpers; they compile to nothing for synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tccs_pkg.sv
// ============================================================================
// Text console package
// Types, codes and defaults shared by the console controller and datapath.
// ============================================================================
package tccs_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int LOC_OUT_W  = 11;
    localparam int INDEX_W    = 11;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          char_code;
        logic [3:0]          bg_color;
        logic [3:0]          fg_color;
        logic [INDEX_W-1:0]  cell_index;
    } t_item;

    typedef struct packed {
        logic [COL_OUT_W-1:0] cursor_column;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [LOC_OUT_W-1:0] cursor_location;
        logic [15:0]          cell_data;
        logic                 scrolled;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic put;
        logic read;
        logic clear_begin;
        logic scroll_begin;
        logic sweep_step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scroll;
        logic sweep_last;
    } t_stat;

endpackage

// File: rtl/tccs_ctrl.sv
// ============================================================================
// Text console controller
// Sequences put, read, clear and scroll work and the reset clearing pass.
// ============================================================================
module tccs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tccs_pkg::t_kind i_kind,
    input  tccs_pkg::t_stat i_stat,
    output tccs_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_PUT   = 6'b000100,
        ST_READ  = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_kind)
                        tccs_pkg::KIND_PUT: begin
                            n_state = ST_PUT;
                        end
                        tccs_pkg::KIND_CLEAR: begin
                            o_cmd.clear_begin = 1'b1;
                            n_state = ST_SWEEP;
                        end
                        tccs_pkg::KIND_READ: begin
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUT: begin
                o_cmd.put = 1'b1;
                if (i_stat.need_scroll) begin
                    o_cmd.scroll_begin = 1'b1;
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state = ST_DONE;
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: rtl/tccs_datapath.sv
// ============================================================================
// Text console datapath
// Screen memory, cursor registers, sweep counter and result register.
// ============================================================================
module tccs_datapath #(
    parameter int COLUMNS  = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS     = tccs_pkg::ROWS_DEF,
    parameter int TAB_STOP = tccs_pkg::TAB_STOP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tccs_pkg::t_item   i_item,
    input  tccs_pkg::t_cmd    i_cmd,
    output tccs_pkg::t_stat   o_stat,
    output logic              o_strobe,
    output tccs_pkg::t_result o_result
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int IW = (AW > tccs_pkg::INDEX_W) ? AW : tccs_pkg::INDEX_W;
    localparam int CW = $clog2(COLUMNS);
    localparam int NW = $clog2(COLUMNS + TAB_STOP);
    localparam int RW = $clog2(ROWS + 1);
    localparam int PW = $clog2(TAB_STOP);

    logic [15:0] mem [CELL_COUNT];

    tccs_pkg::t_item r_item;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [PW-1:0]   r_phase;
    logic            r_scrolled;
    logic [AW-1:0]   r_cnt;
    logic            r_copy;
    logic [15:0]     r_rd_data;
    logic            r_wr_valid;
    logic            r_wr_use_rd;
    logic [AW-1:0]   r_wr_addr;
    logic            r_strobe;
    tccs_pkg::t_result r_result;

    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [PW-1:0] n_phase;
    logic          put_we;
    logic [AW-1:0] put_addr;
    logic [15:0]   put_data;
    logic [AW-1:0] loc_cur;
    logic [NW-1:0] col_ext;
    logic [NW-1:0] col_adv;
    logic          row_inc;
    logic [15:0]   attr;
    logic [IW-1:0] idx_w;
    logic          in_range;
    logic          in_copy;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic          need_scroll;
    logic          sweep_last;

    assign loc_cur  = AW'(r_row * COLUMNS + r_col);
    assign attr     = {r_item.bg_color, r_item.fg_color, 8'h00};
    assign col_ext  = NW'(r_col);
    assign idx_w    = IW'(r_item.cell_index);
    assign in_range = (idx_w < IW'(CELL_COUNT));
    assign in_copy  = r_copy && (r_cnt < AW'(COPY_COUNT));

    // Put interpretation. The phase register tracks the column modulo the
    // tab stop so that a tab needs no divider.
    always_comb begin
        col_adv  = col_ext;
        n_phase  = r_phase;
        row_inc  = 1'b0;
        put_we   = 1'b0;
        put_addr = loc_cur;
        put_data = attr | {8'h00, r_item.char_code};
        if (r_item.char_code == tccs_pkg::CH_BS) begin
            if (r_col != '0) begin
                col_adv  = col_ext - NW'(1);
                put_we   = 1'b1;
                put_addr = loc_cur - AW'(1);
                put_data = attr | {8'h00, tccs_pkg::CH_SPACE};
                n_phase  = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
            end
        end else if (r_item.char_code == tccs_pkg::CH_TAB) begin
            col_adv = col_ext + NW'(TAB_STOP) - NW'(r_phase);
            n_phase = '0;
        end else if (r_item.char_code == tccs_pkg::CH_CR ||
                     r_item.char_code == tccs_pkg::CH_LF) begin
            col_adv = '0;
            n_phase = '0;
            row_inc = 1'b1;
        end else if (r_item.char_code inside {[tccs_pkg::CH_SPACE:tccs_pkg::CH_DEL]}) begin
            put_we  = 1'b1;
            col_adv = col_ext + NW'(1);
            n_phase = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
        end
        // Wrap at the right edge.
        if (col_adv >= NW'(COLUMNS)) begin
            col_adv = '0;
            n_phase = '0;
            row_inc = 1'b1;
        end
        n_col = CW'(col_adv);
        n_row = row_inc ? r_row + RW'(1) : r_row;
        need_scroll = (n_row == RW'(ROWS));
        if (need_scroll) begin
            n_row = RW'(ROWS - 1);
        end
        put_we = put_we && i_cmd.put;
    end

    assign sweep_last = (r_cnt == AW'(CELL_COUNT - 1));
    assign o_stat     = '{need_scroll: need_scroll, sweep_last: sweep_last};

    // Memory port selection.
    assign rd_en   = (i_cmd.sweep_step && in_copy) || (i_cmd.read && in_range);
    assign rd_addr = i_cmd.sweep_step ? r_cnt + AW'(COLUMNS) : AW'(idx_w);
    assign we      = put_we || r_wr_valid;
    assign wa      = put_we ? put_addr : r_wr_addr;
    assign wd      = put_we ? put_data : (r_wr_use_rd ? r_rd_data : tccs_pkg::BLANK_CELL);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_phase    <= '0;
            r_scrolled <= 1'b0;
            r_cnt      <= '0;
            r_copy     <= 1'b0;
            r_wr_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_wr_valid <= i_cmd.sweep_step;
            r_strobe   <= i_cmd.emit;
            if (i_cmd.load) begin
                r_scrolled <= 1'b0;
            end
            if (i_cmd.clear_begin) begin
                r_col   <= '0;
                r_row   <= '0;
                r_phase <= '0;
                r_cnt   <= '0;
                r_copy  <= 1'b0;
            end
            if (i_cmd.put) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_phase <= n_phase;
                if (need_scroll) begin
                    r_scrolled <= 1'b1;
                end
            end
            if (i_cmd.scroll_begin) begin
                r_cnt  <= '0;
                r_copy <= 1'b1;
            end
            if (i_cmd.sweep_step) begin
                r_cnt <= sweep_last ? '0 : r_cnt + AW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.sweep_step) begin
            r_wr_addr   <= r_cnt;
            r_wr_use_rd <= in_copy;
        end
        if (i_cmd.emit) begin
            r_result.cursor_column   <= tccs_pkg::COL_OUT_W'(r_col);
            r_result.cursor_row      <= tccs_pkg::ROW_OUT_W'(r_row);
            r_result.cursor_location <= tccs_pkg::LOC_OUT_W'(r_row * COLUMNS + r_col);
            r_result.cell_data       <= (r_item.kind == tccs_pkg::KIND_READ && in_range) ?
                                        r_rd_data : 16'h0000;
            r_result.scrolled        <= r_scrolled;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: rtl/text_console_cursor_scroll_core.sv
// ============================================================================
// Text console core
// Character-cell screen with cursor, line wrap and scrolling.
// ============================================================================
// A word is taken when start is high and busy is low; every word yields
// exactly one result word, shown on o_result for one cycle with o_strobe
// high, and the receiver must take it then because it cannot stall the
// block. A new word may be accepted in the strobe cycle. Clears and puts
// that scroll sweep the whole screen: the screen memory has one write and
// one read port, so a sweep writes one cell per clock. After reset the
// block runs a clearing pass with busy high before it takes its first word.
`include "assert_macros.svh"

module text_console_cursor_scroll_core #(
    parameter int COLUMNS  = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS     = tccs_pkg::ROWS_DEF,
    parameter int TAB_STOP = tccs_pkg::TAB_STOP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tccs_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output tccs_pkg::t_result o_result
);

    // Command and status between the sequencer and the datapath.
    tccs_pkg::t_cmd  cmd;
    tccs_pkg::t_stat stat;

    // The sequencer steers every word: it latches the word, runs the put or
    // read step, walks the memory for clear and scroll, then emits.
    tccs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_item.kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath holds the screen cells, the cursor and the result word.
    tccs_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // A result appears only once the sequencer is back at rest.
    `ASSERT_IMPLY(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    // An accepted word never produces its result in the following cycle.
    `ASSERT_NEXT(a_accept_quiet, i_clk, i_rst_n, start && !busy, !o_strobe)
    // The reported column always lies on the screen.
    `ASSERT_IMPLY(a_col_range, i_clk, i_rst_n, o_strobe, 8'(o_result.cursor_column) < 8'(COLUMNS))
    // A scroll leaves the cursor on the last row.
    `ASSERT_IMPLY(a_scroll_row, i_clk, i_rst_n, o_strobe && o_result.scrolled, o_result.cursor_row == 5'(ROWS - 1))

endmodule

// File: verif/tb.sv
// ============================================================================
// Text console core testbench
// Sends put, clear, read and unused words to the console core. A
// self-contained screen and cursor model predicts every result word, and the
// testbench checks each strobed result against the oldest expected result. A
// short directed table covers the edges, and a long random run follows it
// under several sender idle rates.
// ============================================================================
module tb;

    // Screen geometry at the default parameter values.
    localparam int COLS  = tccs_pkg::COLUMNS_DEF;
    localparam int ROWS  = tccs_pkg::ROWS_DEF;
    localparam int TABW  = tccs_pkg::TAB_STOP_DEF;
    localparam int CELLS = COLS * ROWS;

    // The random part runs in phases, each with its own sender idle rate.
    localparam int PHASES          = 3;
    localparam int WORDS_PER_PHASE = 434;

    // Slowest legal run: every word a full-screen scroll, plus the clearing
    // pass after reset. This limit is several times that.
    localparam int WATCHDOG_CYCLES = 16_000_000;

    // Cycles to watch for stray strobes once nothing is pending.
    localparam int TAIL_CYCLES = 16;

    localparam int MAX_REPORTS = 10;

    // One row of the directed table. Rows with known_result set carry their
    // expected result in the table; the rest are checked against the screen
    // model.
    typedef struct packed {
        tccs_pkg::t_item   word;
        logic              known_result;
        tccs_pkg::t_result result;
    } t_dir_row;

    localparam int DIR_ROWS = 23;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    tccs_pkg::t_item   i_item;
    logic              busy;
    logic              o_strobe;
    tccs_pkg::t_result o_result;

    // Screen model: one 16-bit cell per screen position and the cursor.
    logic [15:0] screen_model [CELLS];
    int          cur_col;
    int          cur_row;

    // Results predicted for accepted words, oldest first.
    tccs_pkg::t_result pending_results [$];

    int          fail_count;
    int          cycle_count;

    t_dir_row    dir_table [DIR_ROWS];

    text_console_cursor_scroll_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Fills every cell of the screen model with the blank cell.
    function automatic void blank_screen();
        int i;
        for (i = 0; i < CELLS; i++) begin
            screen_model[i] = tccs_pkg::BLANK_CELL;
        end
    endfunction

    // Applies one word to the screen model and returns the result word that
    // the core should strobe for it.
    function automatic tccs_pkg::t_result console_step(input tccs_pkg::t_item w);
        tccs_pkg::t_result r;
        logic [15:0]       attr;
        logic              rolled;
        int                i;
        int                loc;
        r      = '0;
        rolled = 1'b0;
        attr   = {w.bg_color, w.fg_color, 8'h00};
        case (w.kind)
            tccs_pkg::KIND_PUT: begin
                if (w.char_code == tccs_pkg::CH_BS) begin
                    // Backspace at the left edge does nothing at all.
                    if (cur_col != 0) begin
                        cur_col--;
                        screen_model[cur_row * COLS + cur_col] =
                            {attr[15:8], tccs_pkg::CH_SPACE};
                    end
                end else if (w.char_code == tccs_pkg::CH_TAB) begin
                    cur_col = cur_col + TABW - (cur_col % TABW);
                end else if (w.char_code == tccs_pkg::CH_CR ||
                             w.char_code == tccs_pkg::CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (w.char_code >= tccs_pkg::CH_SPACE &&
                             w.char_code <= tccs_pkg::CH_DEL) begin
                    screen_model[cur_row * COLS + cur_col] = {attr[15:8], w.char_code};
                    cur_col++;
                end
                // Wrap at the right edge, then scroll past the last row.
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (i = 0; i < (ROWS - 1) * COLS; i++) begin
                        screen_model[i] = screen_model[i + COLS];
                    end
                    for (i = (ROWS - 1) * COLS; i < CELLS; i++) begin
                        screen_model[i] = tccs_pkg::BLANK_CELL;
                    end
                    cur_row = ROWS - 1;
                    rolled  = 1'b1;
                end
            end
            tccs_pkg::KIND_CLEAR: begin
                blank_screen();
                cur_col = 0;
                cur_row = 0;
            end
            tccs_pkg::KIND_READ: begin
                if (w.cell_index < CELLS) begin
                    r.cell_data = screen_model[w.cell_index];
                end
            end
            default: begin
            end
        endcase
        loc               = cur_row * COLS + cur_col;
        r.cursor_column   = cur_col[tccs_pkg::COL_OUT_W-1:0];
        r.cursor_row      = cur_row[tccs_pkg::ROW_OUT_W-1:0];
        r.cursor_location = loc[tccs_pkg::LOC_OUT_W-1:0];
        r.scrolled        = rolled;
        return r;
    endfunction

    // Picks a byte for a put word. Most are printable so that lines fill
    // and wrap, line ends are common enough to scroll many times, and a
    // share of any byte keeps the ignored codes in play.
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            return 8'($urandom_range(tccs_pkg::CH_DEL, tccs_pkg::CH_SPACE));
        end else if (pick < 72) begin
            return ($urandom_range(1) == 0) ? tccs_pkg::CH_LF : tccs_pkg::CH_CR;
        end else if (pick < 78) begin
            return tccs_pkg::CH_TAB;
        end else if (pick < 86) begin
            return tccs_pkg::CH_BS;
        end
        return 8'($urandom_range(255));
    endfunction

    // Builds one random word. Clears are rare, since each one costs a full
    // sweep and sends the cursor home; reads often look at the cursor row,
    // where recent writes sit, and sometimes straddle the end of the screen.
    function automatic tccs_pkg::t_item random_word();
        tccs_pkg::t_item w;
        int              pick;
        w.kind       = tccs_pkg::t_kind'($urandom_range(3));
        w.char_code  = 8'($urandom_range(255));
        w.bg_color   = 4'($urandom_range(15));
        w.fg_color   = 4'($urandom_range(15));
        w.cell_index = 11'($urandom_range(2047));
        pick = $urandom_range(999);
        if (pick < 4) begin
            w.kind = tccs_pkg::KIND_CLEAR;
        end else if (pick < 30) begin
            w.kind = tccs_pkg::KIND_NONE;
        end else if (pick < 230) begin
            w.kind = tccs_pkg::KIND_READ;
            case ($urandom_range(3))
                0: w.cell_index = 11'($urandom_range(2047));
                1: w.cell_index = 11'($urandom_range(CELLS + 8, CELLS - 8));
                default: w.cell_index = 11'(cur_row * COLS + $urandom_range(COLS - 1));
            endcase
        end else begin
            w.kind      = tccs_pkg::KIND_PUT;
            w.char_code = random_char();
        end
        return w;
    endfunction

    // Counts a failure and prints it while the report budget lasts.
    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // Presents one word and holds it until the core takes it, which is at
    // the first rising edge with start high and busy low. Afterwards the
    // sender may go quiet for a while; start is only lowered in cycles where
    // no new word is presented, so it never sees two assignments in a step.
    task automatic issue_word(input tccs_pkg::t_item w, input int idle_pct);
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        while ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= random_word();
            @(posedge i_clk);
        end
    endtask

    // Result checker. Outputs are sampled at the rising edge, so the values
    // seen are the ones held during the strobe cycle that this edge ends.
    always @(posedge i_clk) begin
        tccs_pkg::t_result want;
        tccs_pkg::t_result got;
        if (i_rst_n && o_strobe) begin
            got = o_result;
            if (pending_results.size() == 0) begin
                report_failure($sformatf("result word with nothing pending: col %0d row %0d",
                                         got.cursor_column, got.cursor_row));
            end else begin
                want = pending_results.pop_front();
                if (got.cursor_column !== want.cursor_column ||
                    got.cursor_row !== want.cursor_row ||
                    got.cursor_location !== want.cursor_location ||
                    got.cell_data !== want.cell_data ||
                    got.scrolled !== want.scrolled) begin
                    report_failure($sformatf(
                        {"result mismatch: expected col %0d row %0d loc %0d data %h scr %0d,",
                         " got col %0d row %0d loc %0d data %h scr %0d"},
                        want.cursor_column, want.cursor_row, want.cursor_location,
                        want.cell_data, want.scrolled,
                        got.cursor_column, got.cursor_row, got.cursor_location,
                        got.cell_data, got.scrolled));
                end
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        tccs_pkg::t_result predicted;
        int                phase_idle [PHASES];
        int                p;
        int                n;

        fail_count = 0;
        phase_idle = '{0, 64, 26};

        // Every input is known from time zero, and reset is asserted first.
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;

        blank_screen();
        cur_col = 0;
        cur_row = 0;

        // Directed words. The first rows probe the reset state: a blank cell,
        // reads past the end of the screen, the unused kind, and a backspace
        // at column zero, which leaves everything as it was. Then the two
        // ends of the printable range with opposite color extremes, the
        // ignored bytes on both sides of that range, tab, backspace with a
        // color, both line ends, and last a clear with a read and an unused word.
        dir_table = '{
            '{'{tccs_pkg::KIND_READ,  8'h00, 4'h0, 4'h0, 11'd0},    1'b1,
              '{7'd0, 5'd0, 11'd0, tccs_pkg::BLANK_CELL, 1'b0}},
            '{'{tccs_pkg::KIND_READ,  8'hFF, 4'hF, 4'hF, 11'd2047}, 1'b1,
              '{7'd0, 5'd0, 11'd0, 16'h0000, 1'b0}},
            '{'{tccs_pkg::KIND_READ,  8'h00, 4'h0, 4'h0, 11'd2000}, 1'b1,
              '{7'd0, 5'd0, 11'd0, 16'h0000, 1'b0}},
            '{'{tccs_pkg::KIND_NONE,  8'hFF, 4'hF, 4'hF, 11'd2047}, 1'b1,
              '{7'd0, 5'd0, 11'd0, 16'h0000, 1'b0}},
            '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CH_BS, 4'hF, 4'hF, 11'd0},    1'b1,
              '{7'd0, 5'd0, 11'd0, 16'h0000, 1'b0}},
            '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CH_SPACE, 4'hF, 4'h0, 11'd0}, 1'b1,
              '{7'd1, 5'd0, 11'd1, 16'h0000, 1'b0}},
            '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CH_DEL, 4'h0, 4'hF, 11'd0},   1'b1,
              '{7'd2, 5'd0, 11'd2, 16'h0000, 1'b0}},
            '{'{tccs_pkg::KIND_READ,  8'h00, 4'h0, 4'h0, 11'd1},    1'b1,
              '{7'd2, 5'd0, 11'd2, 16'h0F7F, 1'b0}},
            '{'{tccs_pkg::KIND_PUT,   8'h1F, 4'h1, 4'h2, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   8'h80, 4'h3, 4'h4, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   8'hFF, 4'h5, 4'h6, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   8'h00, 4'h7, 4'h8, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CH_TAB, 4'h9, 4'hA, 11'd0},   1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CH_BS, 4'hA, 4'h5, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_READ,  8'h00, 4'h0, 4'h0, 11'd7},    1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CH_CR, 4'h0, 4'h0, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CH_LF, 4'h0, 4'h0, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_PUT,   8'h61, 4'h3, 4'hC, 11'd0},    1'b0, '0},
            '{'{tccs_pkg::KIND_READ,  8'h00, 4'h0, 4'h0, 11'd160},  1'b0, '0},
            '{'{tccs_pkg::KIND_READ,  8'h00, 4'h0, 4'h0, 11'd1999}, 1'b0, '0},
            '{'{tccs_pkg::KIND_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0},    1'b1,
              '{7'd0, 5'd0, 11'd0, 16'h0000, 1'b0}},
            '{'{tccs_pkg::KIND_READ,  8'h00, 4'h0, 4'h0, 11'd0},    1'b1,
              '{7'd0, 5'd0, 11'd0, tccs_pkg::BLANK_CELL, 1'b0}},
            '{'{tccs_pkg::KIND_NONE,  8'h00, 4'h0, 4'h0, 11'd0},    1'b1,
              '{7'd0, 5'd0, 11'd0, 16'h0000, 1'b0}}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The clearing pass after reset shows up as busy, which the first
        // word simply waits out.
        for (n = 0; n < DIR_ROWS; n++) begin
            predicted = console_step(dir_table[n].word);
            if (dir_table[n].known_result) begin
                pending_results.push_back(dir_table[n].result);
            end else begin
                pending_results.push_back(predicted);
            end
            issue_word(dir_table[n].word, 0);
        end

        // Random words, one phase per sender idle rate.
        for (p = 0; p < PHASES; p++) begin
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                tccs_pkg::t_item w;
                w = random_word();
                pending_results.push_back(console_step(w));
                issue_word(w, phase_idle[p]);
            end
        end

        start <= 1'b0;

        // Drain, then keep watching for stray strobes for a short while.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
